/* rtl/dq_pkg.sv */
package dq_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_LIST       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       push_front;
    logic       push_rear;
    logic       pop_front;
    logic       pop_rear;
    logic       list_start;
    logic       list_next;
    logic       out_load;
    logic       out_from_mem;
    logic [1:0] out_status;
    logic       out_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] opcode;
    logic       full;
    logic       empty;
    logic       one_left;
    logic       out_free;
  } stat_t;

endpackage

/* rtl/dq_ctrl.sv */
module dq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dq_pkg::stat_t stat,
  output dq_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_POP  = 4'b0100,
    S_LIST = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.out_status = dq_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold the request until the output register can take its word
        if (stat.out_free) begin
          state_next = S_IDLE;
          case (stat.opcode)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (stat.full) begin
                cmd.out_status = dq_pkg::ST_FULL;
              end else if (stat.opcode == dq_pkg::OP_PUSH_FRONT) begin
                cmd.push_front = 1'b1;
              end else begin
                cmd.push_rear = 1'b1;
              end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = dq_pkg::ST_EMPTY;
              end else begin
                cmd.pop_front = (stat.opcode == dq_pkg::OP_POP_FRONT);
                cmd.pop_rear  = (stat.opcode == dq_pkg::OP_POP_REAR);
                state_next    = S_POP;
              end
            end
            dq_pkg::OP_LIST: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = dq_pkg::ST_EMPTY;
              end else begin
                cmd.list_start = 1'b1;
                state_next     = S_LIST;
              end
            end
            default: begin
              // undefined opcodes: no word
            end
          endcase
        end
      end
      S_POP: begin
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_last     = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_LIST: begin
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_last     = stat.one_left;
          if (stat.one_left) begin
            state_next = S_IDLE;
          end else begin
            cmd.list_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/dq_dp.sv */
module dq_dp (
  input  logic          clk,
  input  logic          rst,
  input  dq_pkg::req_t  req,
  output dq_pkg::rsp_t  rsp,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  dq_pkg::cmd_t  cmd,
  output dq_pkg::stat_t stat
);

  localparam logic [dq_pkg::IDX_W-1:0] LAST_IDX = dq_pkg::IDX_W'(dq_pkg::DEPTH - 1);
  localparam logic [dq_pkg::CNT_W-1:0] FULL_CNT = dq_pkg::CNT_W'(dq_pkg::DEPTH);

  function automatic logic [dq_pkg::IDX_W-1:0] wrap_inc(input logic [dq_pkg::IDX_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [dq_pkg::IDX_W-1:0] wrap_dec(input logic [dq_pkg::IDX_W-1:0] p);
    return (p == '0) ? LAST_IDX : p - 1'b1;
  endfunction

  logic [2:0]               op;
  logic signed [31:0]       val;
  logic [dq_pkg::IDX_W-1:0] head;
  logic [dq_pkg::IDX_W-1:0] tail;
  logic [dq_pkg::CNT_W-1:0] count;
  logic [dq_pkg::IDX_W-1:0] lptr;
  logic [dq_pkg::CNT_W-1:0] lcnt;
  logic [31:0]              mem [dq_pkg::DEPTH];
  logic [31:0]              rdata;

  logic [dq_pkg::IDX_W-1:0] head_dec;
  logic [dq_pkg::IDX_W-1:0] tail_dec;
  logic [dq_pkg::IDX_W-1:0] lptr_inc;
  logic                     wr_en;
  logic [dq_pkg::IDX_W-1:0] wr_addr;
  logic                     rd_en;
  logic [dq_pkg::IDX_W-1:0] rd_addr;

  assign head_dec = wrap_dec(head);
  assign tail_dec = wrap_dec(tail);
  assign lptr_inc = wrap_inc(lptr);

  assign wr_en   = cmd.push_front | cmd.push_rear;
  assign wr_addr = cmd.push_front ? head_dec : tail;

  always_comb begin
    rd_en   = cmd.pop_front | cmd.pop_rear | cmd.list_start | cmd.list_next;
    rd_addr = head;
    if (cmd.pop_rear) begin
      rd_addr = tail_dec;
    end else if (cmd.list_next) begin
      rd_addr = lptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= req.opcode;
      val <= req.value;
    end
    if (cmd.list_start) begin
      lptr <= head;
      lcnt <= count;
    end else if (cmd.list_next) begin
      lptr <= lptr_inc;
      lcnt <= lcnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.push_front) begin
        head  <= head_dec;
        count <= count + 1'b1;
      end else if (cmd.push_rear) begin
        tail  <= wrap_inc(tail);
        count <= count + 1'b1;
      end else if (cmd.pop_front) begin
        head  <= wrap_inc(head);
        count <= count - 1'b1;
      end else if (cmd.pop_rear) begin
        tail  <= tail_dec;
        count <= count - 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status <= cmd.out_status;
      rsp.data   <= cmd.out_from_mem ? rdata : 32'sd0;
      rsp.last   <= cmd.out_last;
    end
  end

  assign stat.opcode   = op;
  assign stat.full     = (count == FULL_CNT);
  assign stat.empty    = (count == '0);
  assign stat.one_left = (lcnt == dq_pkg::CNT_W'(1));
  assign stat.out_free = ~rsp_valid | rsp_ready;

endmodule

/* rtl/double_ended_queue_top.sv */
// channel | direction | handshake            | word
// req     | in        | req_valid/req_ready  | dq_pkg::req_t {opcode, value}
// rsp     | out       | rsp_valid/rsp_ready  | dq_pkg::rsp_t {status, data, last}
//
// Accept to result word: push, empty pop and empty list load the output from S_EXEC;
// pop reads the store in S_EXEC, loads in S_POP (registered store read); a list of N
// entries reads the head in S_EXEC, then one word per cycle in S_LIST while rsp is
// ready, the Nth last. A request is taken only in idle; unused opcodes give no word.
// Synchronous active-high reset empties the queue; store contents are not cleared.
// A stalled rsp holds the output register; a request already taken waits for it.
module double_ended_queue_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  dq_pkg::req_t req,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output dq_pkg::rsp_t rsp
);

  dq_pkg::cmd_t  cmd;
  dq_pkg::stat_t stat;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_front || cmd.push_rear) |-> !stat.full)
    else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_front || cmd.pop_rear || cmd.list_start) |-> !stat.empty)
    else $error("read of empty queue");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken while busy");

  a_error_word_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != dq_pkg::ST_OK) |-> (rsp.last && rsp.data == 32'sd0))
    else $error("error word not final or data not zero");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import dq_pkg::*;

  localparam int RANDOM_ITEMS   = 140;
  localparam int WATCHDOG_LIMIT = 500;

  // Reference deque: tracks contents and the result words each request must produce
  class deque_scoreboard;
    logic signed [31:0] slots [DEPTH];
    int front_idx;
    int rear_idx;
    int fill;
    rsp_t expected_words [$];
    int errors;
    int words_seen;
    int op_count [8];
    int full_hits;
    int empty_hits;

    function void add_word(logic [1:0] status, logic signed [31:0] data, logic last);
      rsp_t w;
      w.status = status;
      w.data   = data;
      w.last   = last;
      expected_words.push_back(w);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_request(req_t r);
      int k;
      op_count[r.opcode]++;
      case (r.opcode)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (fill == DEPTH) begin
            full_hits++;
            add_word(ST_FULL, '0, 1'b1);
          end else begin
            if (r.opcode == OP_PUSH_FRONT) begin
              front_idx = (front_idx + DEPTH - 1) % DEPTH;
              slots[IDX_W'(front_idx)] = r.value;
            end else begin
              slots[IDX_W'(rear_idx)] = r.value;
              rear_idx = (rear_idx + 1) % DEPTH;
            end
            fill++;
            add_word(ST_OK, '0, 1'b1);
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (fill == 0) begin
            empty_hits++;
            add_word(ST_EMPTY, '0, 1'b1);
          end else if (r.opcode == OP_POP_FRONT) begin
            add_word(ST_OK, slots[IDX_W'(front_idx)], 1'b1);
            front_idx = (front_idx + 1) % DEPTH;
            fill--;
          end else begin
            rear_idx = (rear_idx + DEPTH - 1) % DEPTH;
            add_word(ST_OK, slots[IDX_W'(rear_idx)], 1'b1);
            fill--;
          end
        end
        OP_LIST: begin
          if (fill == 0) begin
            empty_hits++;
            add_word(ST_EMPTY, '0, 1'b1);
          end else begin
            for (k = 0; k < fill; k++)
              add_word(ST_OK, slots[IDX_W'((front_idx + k) % DEPTH)], k == fill - 1);
          end
        end
        default: ;  // unused opcodes produce nothing
      endcase
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      words_seen++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: status %0d data %0d last %0b",
                 $time, got.status, got.data, got.last);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status,
                 got.status);
        errors++;
      end
      if (got.data !== want.data) begin
        $display("%0t: data mismatch: expected %0d, actual %0d", $time, want.data, got.data);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  deque_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;
  int items_sent = 0;
  logic [15:0] stall_cyc = '0;

  double_ended_queue_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: cycles through always-ready, mostly-ready, sparse and coin-flip windows
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 16'd1;
    case (stall_cyc[8:7])
      2'd0: rsp_ready <= 1'b1;
      2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
      2'd2: rsp_ready <= (stall_cyc[2:0] == 3'd0);
      default: rsp_ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (rsp_valid && rsp_ready)
        sb.check_result(rsp);
      if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the word was taken
  task automatic send_request(input logic [2:0] op, input logic signed [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= '{opcode: op, value: v};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(req);
    if (op <= OP_LIST)
      items_sent++;
  endtask

  // hold the sender until every outstanding result word is back
  task automatic drain_pending();
    req_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int seg;
    int mode;
    int pick;
    int first_random;
    logic [2:0] op;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, extremes at both ends, unused opcodes
    send_request(OP_LIST, $urandom);
    send_request(OP_POP_FRONT, $urandom);
    send_request(OP_POP_REAR, $urandom);
    send_request(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(OP_PUSH_REAR, 32'h8000_0000);
    send_request(OP_PUSH_FRONT, 32'h0000_0000);
    send_request(OP_PUSH_REAR, 32'hFFFF_FFFF);
    send_request(OP_LIST, $urandom);
    send_request(OP_POP_FRONT, $urandom);
    send_request(OP_POP_REAR, $urandom);
    send_request(3'd5, $urandom);
    send_request(3'd6, $urandom);
    send_request(3'd7, $urandom);
    send_request(OP_PUSH_REAR, 32'h5555_5555);
    send_request(OP_PUSH_FRONT, 32'hAAAA_AAAA);
    send_request(OP_LIST, $urandom);
    send_request(OP_POP_REAR, $urandom);
    send_request(OP_POP_FRONT, $urandom);
    send_request(OP_POP_FRONT, $urandom);
    send_request(OP_POP_REAR, $urandom);
    send_request(OP_POP_REAR, $urandom);
    send_request(OP_LIST, $urandom);
    drain_pending();

    // random: fill-to-full and drain-to-empty runs, mixed traffic, occasional hold-off
    first_random = items_sent;
    seg = 0;
    while (items_sent < first_random + RANDOM_ITEMS) begin
      mode = (seg < 2) ? seg : $urandom_range(0, 9);
      seg++;
      if (mode == 0) begin
        while (sb.fill < DEPTH)
          send_request($urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT, pick_value());
        repeat ($urandom_range(1, 2))
          send_request($urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT, pick_value());
        send_request(OP_LIST, $urandom);
      end else if (mode == 1) begin
        while (sb.fill > 0)
          send_request($urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT, $urandom);
        send_request($urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT, $urandom);
        send_request(OP_LIST, $urandom);
      end else if (mode == 2) begin
        drain_pending();
      end else begin
        repeat ($urandom_range(6, 16)) begin
          pick = $urandom_range(0, 99);
          if (pick < 40)
            op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
          else if (pick < 78)
            op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
          else if (pick < 92)
            op = OP_LIST;
          else
            op = 3'($urandom_range(5, 7));
          send_request(op, pick_value());
        end
      end
    end

    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // keep watching past the last expected word so that stray extra words are still caught
    repeat (DEPTH + 8) @(posedge clk);

    $display("covered %0d pushes, %0d pops, %0d lists, %0d unused-opcode requests",
             sb.op_count[OP_PUSH_FRONT] + sb.op_count[OP_PUSH_REAR],
             sb.op_count[OP_POP_FRONT] + sb.op_count[OP_POP_REAR], sb.op_count[OP_LIST],
             sb.op_count[5] + sb.op_count[6] + sb.op_count[7]);
    $display("%0d result words checked, full seen %0d times, empty seen %0d times, %0d errors",
             sb.words_seen, sb.full_hits, sb.empty_hits, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
